// File: design/qrt_pkg.sv
// Shared types and codes for the QoS retransmit tracker.
// No dependencies; imported by the tracker top level and its checker.
package qrt_pkg;

  localparam int SLOT_W = 3;

  // command codes of an input beat
  localparam logic [1:0] CMD_PUBLISH = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_PUBREC  = 2'd2;
  localparam logic [1:0] CMD_CHECK   = 2'd3;

  // QoS levels
  localparam logic [1:0] QOS_0   = 2'd0;
  localparam logic [1:0] QOS_1   = 2'd1;
  localparam logic [1:0] QOS_2   = 2'd2;
  localparam logic [1:0] QOS_BAD = 2'd3;

  // result event codes
  localparam logic [3:0] EV_STORED      = 4'd0;
  localparam logic [3:0] EV_UNTRACKED   = 4'd1;
  localparam logic [3:0] EV_FULL        = 4'd2;
  localparam logic [3:0] EV_REMOVED     = 4'd3;
  localparam logic [3:0] EV_PUBREL_DUE  = 4'd4;
  localparam logic [3:0] EV_RESEND_PUB  = 4'd5;
  localparam logic [3:0] EV_RESEND_REL  = 4'd6;
  localparam logic [3:0] EV_GAVE_UP     = 4'd7;
  localparam logic [3:0] EV_CHECK_DONE  = 4'd8;

  // configuration register indexes
  localparam logic CFG_RETRY_INTERVAL = 1'b0;
  localparam logic CFG_MAX_RETRIES    = 1'b1;

  localparam logic [31:0] RETRY_INTERVAL_RST = 32'd1000000;
  localparam logic [7:0]  MAX_RETRIES_RST    = 8'd3;

  // one slot of the table memory
  typedef struct packed {
    logic [15:0] msg_id;
    logic [15:0] topic;
    logic [1:0]  qos;
    logic        rel_step;
    logic [31:0] stamp;
    logic [7:0]  retries;
  } entry_t;

  // one result beat
  typedef struct packed {
    logic [3:0]        event_res;
    logic              matched;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       msg_id;
    logic [15:0]       topic;
    logic [1:0]        qos;
    logic              last;
  } res_t;

endpackage

// File: design/qos_retransmit_tracker.sv
// QoS 1/2 retransmit tracker: slot table in a simple dual-port synchronous memory
// plus in-use flags in flops. Depends on qrt_pkg.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+--------------------------------------
//   input    | in        | in_valid_i / in_stall_o  | cmd, now_time, msg_id, topic, qos
//   result   | out       | out_valid_o / out_stall_i| event_res, matched, slot, out_msg_id,
//            |           |                          | out_topic, out_qos, last
//   config   | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// Publish beats are decided in ST_PUB. Ack, PUBREC and check beats walk the table
// from slot 0 in ST_SCAN, and a check ends with its done beat from ST_DONE. The walk reads one
// table entry per cycle through the single memory read port unless a hit waits on a stalled result.
// Reset clears the in-use flags and loads register defaults; no clearing pass.
// One input beat is in work at a time; in_stall_o is high until it finishes.
module qos_retransmit_tracker
  import qrt_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] now_time_i,
  input  logic [15:0] msg_id_i,
  input  logic [15:0] topic_i,
  input  logic [1:0]  qos_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  event_res_o,
  output logic        matched_o,
  output logic [2:0]  slot_o,
  output logic [15:0] out_msg_id_o,
  output logic [15:0] out_topic_o,
  output logic [1:0]  out_qos_o,
  output logic        last_o
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUB  = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [SLOTS-1:0] in_use_q, in_use_d;
  logic [31:0]      retry_interval_q;
  logic [7:0]       max_retries_q;

  logic [1:0]  cmd_q;
  logic [31:0] now_q;
  logic [15:0] id_q;
  logic [15:0] tp_q;
  logic [1:0]  qos_q;

  entry_t           entry_mem_q [SLOTS];
  entry_t           rd_entry_q;
  entry_t           wr_entry;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] waddr, raddr;

  res_t out_q, res;
  logic out_valid_q, out_valid_d;
  logic emit, out_free, in_accept;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [31:0]      age;
  logic             hit, give_up;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign age     = now_q - rd_entry_q.stamp;
  assign give_up = (rd_entry_q.retries >= max_retries_q);

  always_comb begin
    if (cmd_q == CMD_CHECK) begin
      hit = in_use_q[idx_q] && (age > retry_interval_q);
    end else begin
      hit = in_use_q[idx_q] && (rd_entry_q.msg_id == id_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    in_use_d = in_use_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    waddr    = idx_q;
    raddr    = idx_q;
    wr_entry = rd_entry_q;
    emit     = 1'b0;
    res      = '{event_res: EV_CHECK_DONE, matched: 1'b0, slot: '0,
                 msg_id: '0, topic: '0, qos: '0, last: 1'b1};

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (cmd_i == CMD_PUBLISH) begin
            state_d = ST_PUB;
          end else begin
            idx_d   = '0;
            raddr   = '0;
            mem_re  = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end

      ST_PUB: begin
        res.msg_id = id_q;
        res.topic  = tp_q;
        res.qos    = qos_q;
        if (qos_q == QOS_0 || qos_q == QOS_BAD) begin
          res.event_res = EV_UNTRACKED;
        end else if (free_found) begin
          res.event_res = EV_STORED;
          res.slot      = SLOT_W'(free_idx);
        end else begin
          res.event_res = EV_FULL;
        end
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (res.event_res == EV_STORED) begin
            mem_we             = 1'b1;
            waddr              = free_idx;
            wr_entry.msg_id    = id_q;
            wr_entry.topic     = tp_q;
            wr_entry.qos       = qos_q;
            wr_entry.rel_step  = 1'b0;
            wr_entry.stamp     = now_q;
            wr_entry.retries   = '0;
            in_use_d[free_idx] = 1'b1;
          end
        end
      end

      ST_SCAN: begin
        if (cmd_q != CMD_CHECK) begin
          res.event_res = (cmd_q == CMD_ACK) ? EV_REMOVED : EV_PUBREL_DUE;
          if (hit) begin
            res.matched = 1'b1;
            res.slot    = SLOT_W'(idx_q);
            res.msg_id  = rd_entry_q.msg_id;
            res.topic   = rd_entry_q.topic;
            res.qos     = rd_entry_q.qos;
            if (out_free) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
              if (cmd_q == CMD_ACK) begin
                in_use_d[idx_q] = 1'b0;
              end else begin
                mem_we            = 1'b1;
                wr_entry.rel_step = 1'b1;
                wr_entry.stamp    = now_q;
              end
            end
          end else if (idx_q == LAST_IDX) begin
            res.msg_id = id_q;
            if (out_free) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            idx_d  = idx_q + IDX_W'(1);
            raddr  = idx_d;
            mem_re = 1'b1;
          end
        end else begin
          res.matched = 1'b1;
          res.slot    = SLOT_W'(idx_q);
          res.msg_id  = rd_entry_q.msg_id;
          res.topic   = rd_entry_q.topic;
          res.qos     = rd_entry_q.qos;
          res.last    = 1'b0;
          if (give_up) begin
            res.event_res = EV_GAVE_UP;
          end else if (rd_entry_q.qos == QOS_2 && rd_entry_q.rel_step) begin
            res.event_res = EV_RESEND_REL;
          end else begin
            res.event_res = EV_RESEND_PUB;
          end
          if (hit && out_free) begin
            emit = 1'b1;
            if (give_up) begin
              in_use_d[idx_q] = 1'b0;
            end else begin
              mem_we           = 1'b1;
              wr_entry.retries = rd_entry_q.retries + 8'd1;
              wr_entry.stamp   = now_q;
            end
          end
          // a due slot holds the walk until its beat goes out
          if (!hit || out_free) begin
            if (idx_q == LAST_IDX) begin
              state_d = ST_DONE;
            end else begin
              idx_d  = idx_q + IDX_W'(1);
              raddr  = idx_d;
              mem_re = 1'b1;
            end
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      in_use_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      in_use_q    <= in_use_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_interval_q <= RETRY_INTERVAL_RST;
      max_retries_q    <= MAX_RETRIES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RETRY_INTERVAL: retry_interval_q <= cfg_data_i;
        CFG_MAX_RETRIES:    max_retries_q    <= cfg_data_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_i;
      now_q <= now_time_i;
      id_q  <= msg_id_i;
      tp_q  <= topic_i;
      qos_q <= qos_i;
    end
    if (emit) begin
      out_q <= res;
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[waddr] <= wr_entry;
    end
    if (mem_re) begin
      rd_entry_q <= entry_mem_q[raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_res_o  = out_q.event_res;
  assign matched_o    = out_q.matched;
  assign slot_o       = out_q.slot;
  assign out_msg_id_o = out_q.msg_id;
  assign out_topic_o  = out_q.topic;
  assign out_qos_o    = out_q.qos;
  assign last_o       = out_q.last;

endmodule

// File: design/qrt_checker.sv
// Port-level checks for qos_retransmit_tracker, attached by bind.
// Depends on qrt_pkg for the event codes.
module qrt_checker
  import qrt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  event_res_o,
  input logic        matched_o,
  input logic [2:0]  slot_o,
  input logic [15:0] out_msg_id_o,
  input logic        last_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) &&
      $stable(slot_o) && $stable(out_msg_id_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in work");

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_res_o <= EV_CHECK_DONE)
    else $error("event code out of range");

  // only per-slot check events leave the item open
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == !(event_res_o == EV_RESEND_PUB ||
      event_res_o == EV_RESEND_REL || event_res_o == EV_GAVE_UP)))
    else $error("last flag does not fit the event");

  a_matched_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && matched_o |-> (event_res_o == EV_REMOVED ||
      event_res_o == EV_PUBREL_DUE || event_res_o == EV_RESEND_PUB ||
      event_res_o == EV_RESEND_REL || event_res_o == EV_GAVE_UP))
    else $error("matched set on an event without a slot");

endmodule

bind qos_retransmit_tracker qrt_checker u_qrt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .event_res_o  (event_res_o),
  .matched_o    (matched_o),
  .slot_o       (slot_o),
  .out_msg_id_o (out_msg_id_o),
  .last_o       (last_o)
);

// File: tb/tb_qos_retransmit_tracker.sv
// Self-checking testbench for qos_retransmit_tracker: random and directed command
// beats against a cycle-free predictor of the slot table. Depends on qrt_pkg and the RTL.
module tb_qos_retransmit_tracker;
  import qrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS     = 8;
  localparam int SETTLE    = SLOTS + 4;
  localparam int MAX_CYCLE = 200000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now;
    logic [15:0] msg_id;
    logic [15:0] topic;
    logic [1:0]  qos;
  } tracker_cmd_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic        cfg_idx_i      = CFG_RETRY_INTERVAL;
  logic [31:0] cfg_data_i     = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i          = CMD_PUBLISH;
  logic [31:0] now_time_i     = '0;
  logic [15:0] msg_id_i       = '0;
  logic [15:0] topic_i        = '0;
  logic [1:0]  qos_i          = QOS_0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [3:0]  event_res_o;
  logic        matched_o;
  logic [2:0]  slot_o;
  logic [15:0] out_msg_id_o;
  logic [15:0] out_topic_o;
  logic [1:0]  out_qos_o;
  logic        last_o;

  qos_retransmit_tracker #(.SLOTS(SLOTS)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .cmd_i, .now_time_i, .msg_id_i, .topic_i, .qos_i,
    .out_valid_o, .out_stall_i, .event_res_o, .matched_o, .slot_o,
    .out_msg_id_o, .out_topic_o, .out_qos_o, .last_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state: slot table and register copies
  logic [SLOTS-1:0] slot_busy = '0;
  entry_t           slot_tab[SLOTS];
  logic [31:0]      model_interval = RETRY_INTERVAL_RST;
  logic [7:0]       model_max      = MAX_RETRIES_RST;

  tracker_cmd_t cmd_backlog[$];
  res_t         expected_events[$];

  int  n_queued = 0;
  int  n_accepted = 0;
  int  beats_checked = 0;
  int  mismatches = 0;
  int  n_resends = 0;
  int  n_gave_up = 0;
  int  n_full = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;

  logic [31:0] clock_now = '0;
  logic [15:0] id_pool[8];
  int          pool_wr = 0;

  task automatic track_item(input tracker_cmd_t c);
    res_t        r;
    int          hit;
    int          i;
    logic [31:0] age;
    hit = -1;
    r = '0;
    r.last = 1'b1;
    case (c.cmd)
      CMD_PUBLISH: begin
        r.msg_id = c.msg_id;
        r.topic  = c.topic;
        r.qos    = c.qos;
        if (c.qos == QOS_0 || c.qos == QOS_BAD) begin
          r.event_res = EV_UNTRACKED;
        end else begin
          for (i = 0; i < SLOTS; i++)
            if (!slot_busy[i] && hit < 0) hit = i;
          if (hit < 0) begin
            r.event_res = EV_FULL;
            n_full++;
          end else begin
            slot_busy[hit] = 1'b1;
            slot_tab[hit] = '{msg_id: c.msg_id, topic: c.topic, qos: c.qos,
                              rel_step: 1'b0, stamp: c.now, retries: 8'd0};
            r.event_res = EV_STORED;
            r.slot = SLOT_W'(hit);
          end
        end
        expected_events.push_back(r);
      end
      CMD_ACK, CMD_PUBREC: begin
        for (i = 0; i < SLOTS; i++)
          if (slot_busy[i] && slot_tab[i].msg_id == c.msg_id && hit < 0) hit = i;
        r.event_res = (c.cmd == CMD_ACK) ? EV_REMOVED : EV_PUBREL_DUE;
        r.msg_id = c.msg_id;
        if (hit >= 0) begin
          r.matched = 1'b1;
          r.slot    = SLOT_W'(hit);
          r.topic   = slot_tab[hit].topic;
          r.qos     = slot_tab[hit].qos;
          if (c.cmd == CMD_ACK) begin
            slot_busy[hit] = 1'b0;
          end else begin
            slot_tab[hit].rel_step = 1'b1;
            slot_tab[hit].stamp    = c.now;
          end
        end
        expected_events.push_back(r);
      end
      default: begin
        for (i = 0; i < SLOTS; i++) begin
          if (slot_busy[i]) begin
            age = c.now - slot_tab[i].stamp;
            if (age > model_interval) begin
              r = '0;
              r.matched = 1'b1;
              r.slot    = SLOT_W'(i);
              r.msg_id  = slot_tab[i].msg_id;
              r.topic   = slot_tab[i].topic;
              r.qos     = slot_tab[i].qos;
              if (slot_tab[i].retries >= model_max) begin
                r.event_res = EV_GAVE_UP;
                slot_busy[i] = 1'b0;
                n_gave_up++;
              end else begin
                r.event_res = (slot_tab[i].qos == QOS_2 && slot_tab[i].rel_step) ?
                              EV_RESEND_REL : EV_RESEND_PUB;
                slot_tab[i].retries = slot_tab[i].retries + 8'd1;
                slot_tab[i].stamp   = c.now;
                n_resends++;
              end
              expected_events.push_back(r);
            end
          end
        end
        r = '0;
        r.event_res = EV_CHECK_DONE;
        r.last = 1'b1;
        expected_events.push_back(r);
      end
    endcase
  endtask

  // sender: one command beat at a time from the backlog, random gaps between beats
  tracker_cmd_t tx_cur;
  int           tx_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        track_item(tx_cur);
        n_accepted++;
        tx_gap = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          tx_cur = cmd_backlog.pop_front();
          cmd_i      <= tx_cur.cmd;
          now_time_i <= tx_cur.now;
          msg_id_i   <= tx_cur.msg_id;
          topic_i    <= tx_cur.topic;
          qos_i      <= tx_cur.qos;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: random stall after each result beat, compare against oldest expectation
  int rx_wait = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{event_res: event_res_o, matched: matched_o, slot: slot_o,
                msg_id: out_msg_id_o, topic: out_topic_o, qos: out_qos_o,
                last: last_o};
        beats_checked++;
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result beat: ev=%0d slot=%0d id=%h", $realtime,
                     got.event_res, got.slot, got.msg_id);
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] result mismatch: got ev=%0d m=%0d slot=%0d id=%h tp=%h q=%0d last=%0d",
                       $realtime, got.event_res, got.matched, got.slot, got.msg_id,
                       got.topic, got.qos, got.last);
              $display("    want ev=%0d m=%0d slot=%0d id=%h tp=%h q=%0d last=%0d",
                       want.event_res, want.matched, want.slot, want.msg_id,
                       want.topic, want.qos, want.last);
            end
          end
        end
        rx_wait = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               expected_events.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic tracker_cmd_t mk(logic [1:0] cmd, logic [31:0] now, logic [15:0] id,
                                      logic [15:0] topic, logic [1:0] qos);
    return '{cmd: cmd, now: now, msg_id: id, topic: topic, qos: qos};
  endfunction

  task automatic queue_cmd(input tracker_cmd_t c);
    cmd_backlog.push_back(c);
    n_queued++;
  endtask

  // block is idle once every beat is accepted and every result has come back
  task automatic wait_idle();
    while (!(n_accepted == n_queued && expected_events.size() == 0))
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_RETRY_INTERVAL) model_interval = data;
    else model_max = data[7:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] age_step();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, model_interval / 2);
      1: return model_interval;
      2: return model_interval + 32'd1;
      default: return $urandom;
    endcase
  endfunction

  // publish/ack/pubrec/check traffic plus some fully random beats; ack/pubrec ids mostly from a pool of published ones
  task automatic gen_phase(input int n);
    int          k;
    int          pick;
    logic [15:0] id;
    logic [1:0]  q;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      clock_now = clock_now + $urandom_range(0, 15);
      id = ($urandom_range(0, 4) != 0) ? id_pool[$urandom_range(0, 7)] : 16'($urandom);
      if (pick < 32) begin
        if ($urandom_range(0, 9) < 8) q = 2'($urandom_range(1, 2));
        else q = $urandom_range(0, 1) ? QOS_0 : QOS_BAD;
        if ($urandom_range(0, 3) != 0) id = 16'($urandom);
        id_pool[pool_wr] = id;
        pool_wr = (pool_wr + 1) % 8;
        queue_cmd(mk(CMD_PUBLISH, clock_now, id, 16'($urandom), q));
      end else if (pick < 52) begin
        queue_cmd(mk(CMD_ACK, clock_now, id, 16'($urandom), 2'($urandom)));
      end else if (pick < 66) begin
        queue_cmd(mk(CMD_PUBREC, clock_now, id, 16'($urandom), 2'($urandom)));
      end else if (pick < 94) begin
        clock_now = clock_now + age_step();
        queue_cmd(mk(CMD_CHECK, clock_now, 16'($urandom), 16'($urandom), 2'($urandom)));
      end else begin
        queue_cmd(mk(2'($urandom), $urandom, 16'($urandom), 16'($urandom), 2'($urandom)));
      end
    end
  endtask

  initial begin
    logic [31:0] t0;
    logic [31:0] tc;
    int          s;
    for (s = 0; s < 8; s++) id_pool[s] = 16'($urandom);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: untracked QoS 0 and 3, fill to full with a duplicate id, acks and
    // pubrecs with and without a match, boundary age, wrapped age, resends, give-up
    t0 = 32'hFFFF_FFF0;
    queue_cmd(mk(CMD_PUBLISH, 32'h0, 16'h0000, 16'h0000, QOS_0));
    queue_cmd(mk(CMD_PUBLISH, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, QOS_BAD));
    queue_cmd(mk(CMD_PUBLISH, t0, 16'hFFFF, 16'hFFFF, QOS_1));
    queue_cmd(mk(CMD_PUBLISH, t0, 16'h0000, 16'h0000, QOS_2));
    queue_cmd(mk(CMD_PUBLISH, t0, 16'h0000, 16'h0001, QOS_1));
    for (s = 3; s < SLOTS; s++)
      queue_cmd(mk(CMD_PUBLISH, t0, 16'h0101 + 16'(s - 3), 16'h5A00 + 16'(s),
                   (s % 2 == 1) ? QOS_2 : QOS_1));
    queue_cmd(mk(CMD_PUBLISH, t0, 16'h0200, 16'h00AA, QOS_2));
    queue_cmd(mk(CMD_ACK, t0, 16'h0000, 16'hFFFF, QOS_BAD));
    queue_cmd(mk(CMD_ACK, t0, 16'hBEEF, 16'h1234, QOS_1));
    queue_cmd(mk(CMD_PUBREC, t0, 16'h7777, 16'hFFFF, QOS_BAD));
    queue_cmd(mk(CMD_PUBREC, t0, 16'h0000, 16'h0000, QOS_0));
    queue_cmd(mk(CMD_PUBREC, t0, 16'h0103, 16'h0000, QOS_0));
    tc = t0 + RETRY_INTERVAL_RST;
    queue_cmd(mk(CMD_CHECK, tc, 16'h0, 16'h0, QOS_0));
    for (s = 0; s < 4; s++) begin
      tc = tc + 32'd1 + ((s == 0) ? 32'd0 : RETRY_INTERVAL_RST);
      queue_cmd(mk(CMD_CHECK, tc, 16'hFFFF, 16'hFFFF, QOS_BAD));
    end
    clock_now = tc;
    wait_idle();

    // random phases over several register settings
    write_cfg(CFG_RETRY_INTERVAL, 32'd1000);
    write_cfg(CFG_MAX_RETRIES, 32'd2);
    gen_phase(12);
    wait_idle();
    gen_phase(12);
    wait_idle();

    no_idle = 1'b1;
    write_cfg(CFG_RETRY_INTERVAL, 32'd0);
    write_cfg(CFG_MAX_RETRIES, 32'd0);
    gen_phase(18);
    wait_idle();
    no_idle = 1'b0;

    write_cfg(CFG_RETRY_INTERVAL, 32'hFFFF_FFFF);
    write_cfg(CFG_MAX_RETRIES, 32'd255);
    gen_phase(14);
    wait_idle();

    write_cfg(CFG_RETRY_INTERVAL, 32'd40);
    write_cfg(CFG_MAX_RETRIES, 32'd1);
    gen_phase(16);
    wait_idle();

    write_cfg(CFG_RETRY_INTERVAL, $urandom_range(1, 5000));
    write_cfg(CFG_MAX_RETRIES, $urandom_range(0, 4));
    gen_phase(16);
    wait_idle();

    $display("ran %0d command beats over 6 register settings, %0d result beats checked",
             n_accepted, beats_checked);
    $display("predicted %0d resends, %0d give-ups, %0d full-table rejects, %0d mismatches",
             n_resends, n_gave_up, n_full, mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
